// ===== design/bpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary to packed BCD package
// Widths, count tables and the shift-and-add-3 digit correction used by the
// converter pipeline.
// ----------------------------------------------------------------------------
package bpb_pkg;

	localparam int VALUE_W       = 64;
	localparam int LEN_W         = 4;
	localparam int BYTE_W        = 8;
	localparam int DIGIT_W       = 4;
	localparam int NUM_DIGITS    = 20;
	localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
	localparam int BCD_LOW_W     = 64;
	localparam int BCD_HIGH_W    = BCD_W - BCD_LOW_W;
	localparam int DIGIT_COUNT_W = 5;
	localparam int BYTE_COUNT_W  = 4;

	typedef logic [BCD_W-1:0]         bcd_t;
	typedef logic [BYTE_W-1:0]        byte_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [DIGIT_COUNT_W-1:0] digit_count_t;
	typedef logic [BYTE_COUNT_W-1:0]  byte_count_t;

	// Digits needed for the largest value of each byte length.
	function automatic digit_count_t digits_for_len(input len_t len);
		digit_count_t d;
		unique case (len)
			4'd1:    d = 5'd3;
			4'd2:    d = 5'd5;
			4'd3:    d = 5'd8;
			4'd4:    d = 5'd10;
			4'd5:    d = 5'd13;
			4'd6:    d = 5'd15;
			4'd7:    d = 5'd17;
			4'd8:    d = 5'd20;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

	// Packed BCD bytes for each byte length.
	function automatic byte_count_t bytes_for_len(input len_t len);
		byte_count_t b;
		unique case (len)
			4'd1:    b = 4'd2;
			4'd2:    b = 4'd3;
			4'd3:    b = 4'd4;
			4'd4:    b = 4'd5;
			4'd5:    b = 4'd7;
			4'd6:    b = 4'd8;
			4'd7:    b = 4'd9;
			4'd8:    b = 4'd10;
			default: b = 4'd0;
		endcase
		return b;
	endfunction

	// One double-dabble step: correct every digit of five or more by adding
	// three, then shift the next binary bit in at the bottom.
	function automatic bcd_t dabble_step(input bcd_t bcd, input logic bit_in);
		bcd_t fixed;
		fixed = bcd;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (bcd[k*DIGIT_W +: DIGIT_W] >= 4'd5)
				fixed[k*DIGIT_W +: DIGIT_W] = bcd[k*DIGIT_W +: DIGIT_W] + 4'd3;
		end
		return {fixed[BCD_W-2:0], bit_in};
	endfunction

	// Eight steps, most significant bit of the byte first.
	function automatic bcd_t dabble_byte(input bcd_t bcd, input byte_t b);
		bcd_t acc;
		acc = bcd;
		for (int i = BYTE_W - 1; i >= 0; i--)
			acc = dabble_step(acc, b[i]);
		return acc;
	endfunction

endpackage

// ===== design/binary_to_packed_bcd.sv =====
// ----------------------------------------------------------------------------
// Binary to packed BCD converter
// Pipelined double-dabble conversion of a 1 to 8 byte binary value into
// twenty packed BCD digits, with digit and byte counts.
// ----------------------------------------------------------------------------
// A beat is taken whenever start is high; busy is always low, so a new value
// may be issued every cycle. Each beat comes out after the masking stage and
// every conversion stage as a one-cycle done strobe with bcd_low, bcd_high,
// digit_count and byte_count; the receiver cannot stall, so results must be
// captured on that cycle. The first stage masks the bytes beyond length_bytes
// and looks up the counts; each following stage shifts one input byte into
// the BCD digits (eight shift-and-add-3 steps).
// A length of zero or above MAX_INPUT_BYTES yields all zeros.
module binary_to_packed_bcd #(
	parameter int MAX_INPUT_BYTES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [bpb_pkg::VALUE_W-1:0]        value_in,
	input  logic [bpb_pkg::LEN_W-1:0]          length_bytes,
	output logic                               done,
	output logic [bpb_pkg::BCD_LOW_W-1:0]      bcd_low,
	output logic [bpb_pkg::BCD_HIGH_W-1:0]     bcd_high,
	output logic [bpb_pkg::DIGIT_COUNT_W-1:0]  digit_count,
	output logic [bpb_pkg::BYTE_COUNT_W-1:0]   byte_count
);

	localparam int NB = MAX_INPUT_BYTES * bpb_pkg::BYTE_W;

	// Stage 1: masking and count lookup.
	logic                        valid_s1;
	logic [NB-1:0]               bin_s1;
	bpb_pkg::digit_count_t       dig_s1;
	bpb_pkg::byte_count_t        byt_s1;

	// Conversion stages, one input byte each; index 0 is stage 2.
	logic                        valid_sx [MAX_INPUT_BYTES];
	logic [NB-1:0]               bin_sx   [MAX_INPUT_BYTES];
	bpb_pkg::bcd_t               bcd_sx   [MAX_INPUT_BYTES];
	bpb_pkg::digit_count_t       dig_sx   [MAX_INPUT_BYTES];
	bpb_pkg::byte_count_t        byt_sx   [MAX_INPUT_BYTES];

	logic                        len_ok;
	logic [NB-1:0]               masked;

	assign busy   = 1'b0;
	assign len_ok = (length_bytes != '0) &&
		(length_bytes <= bpb_pkg::LEN_W'(MAX_INPUT_BYTES));

	always_comb begin
		masked = value_in[NB-1:0];
		for (int b = 0; b < MAX_INPUT_BYTES; b++) begin
			if (!len_ok || (bpb_pkg::LEN_W'(b) >= length_bytes))
				masked[b*bpb_pkg::BYTE_W +: bpb_pkg::BYTE_W] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		bin_s1 <= masked;
		dig_s1 <= len_ok ? bpb_pkg::digits_for_len(length_bytes) : '0;
		byt_s1 <= len_ok ? bpb_pkg::bytes_for_len(length_bytes) : '0;
	end

	for (genvar s = 0; s < MAX_INPUT_BYTES; s++) begin : g_stage
		logic                  valid_in;
		logic [NB-1:0]         bin_in;
		bpb_pkg::bcd_t         bcd_in;
		bpb_pkg::digit_count_t dig_in;
		bpb_pkg::byte_count_t  byt_in;

		if (s == 0) begin : g_first
			assign valid_in = valid_s1;
			assign bin_in   = bin_s1;
			assign bcd_in   = '0;
			assign dig_in   = dig_s1;
			assign byt_in   = byt_s1;
		end else begin : g_next
			assign valid_in = valid_sx[s-1];
			assign bin_in   = bin_sx[s-1];
			assign bcd_in   = bcd_sx[s-1];
			assign dig_in   = dig_sx[s-1];
			assign byt_in   = byt_sx[s-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sx[s] <= 1'b0;
			end else begin
				valid_sx[s] <= valid_in;
			end
		end

		// The most significant remaining byte is consumed, the rest moves up.
		always_ff @(posedge clk) begin
			bcd_sx[s] <= bpb_pkg::dabble_byte(bcd_in, bin_in[NB-1 -: bpb_pkg::BYTE_W]);
			bin_sx[s] <= bin_in << bpb_pkg::BYTE_W;
			dig_sx[s] <= dig_in;
			byt_sx[s] <= byt_in;
		end
	end

	assign done        = valid_sx[MAX_INPUT_BYTES-1];
	assign bcd_low     = bcd_sx[MAX_INPUT_BYTES-1][bpb_pkg::BCD_LOW_W-1:0];
	assign bcd_high    = bcd_sx[MAX_INPUT_BYTES-1][bpb_pkg::BCD_W-1:bpb_pkg::BCD_LOW_W];
	assign digit_count = dig_sx[MAX_INPUT_BYTES-1];
	assign byte_count  = byt_sx[MAX_INPUT_BYTES-1];

endmodule
